// File: src/asf_pkg.sv
// Shared constants, types and codes for the address sort and filter block.
package asf_pkg;

  localparam int unsigned POOL_DEPTH = 1024;
  localparam int unsigned AW         = $clog2(POOL_DEPTH);
  localparam int unsigned CW         = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned OCTET_W    = 8;
  localparam int unsigned OUT_USER_W = 5;

  typedef logic [AW-1:0]      idx_t;
  typedef logic [CW-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [OCTET_W-1:0] octet_t;
  typedef logic [2:0]         pass_t;

  // pass code after the last pass: sequence exhausted
  localparam pass_t PASS_END = 3'd4;

  localparam octet_t MATCH_FIRST_RST = 8'd1;
  localparam octet_t PAIR_FIRST_RST  = 8'd46;
  localparam octet_t PAIR_SECOND_RST = 8'd70;
  localparam octet_t MATCH_ANY_RST   = 8'd46;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NOP    = 2'd3
  } asf_req_e;

  typedef enum logic [1:0] {
    CFG_MATCH_FIRST = 2'd0,
    CFG_PAIR_FIRST  = 2'd1,
    CFG_PAIR_SECOND = 2'd2,
    CFG_MATCH_ANY   = 2'd3
  } asf_cfg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_INS_START,
    OP_INS_SHIFT,
    OP_PUT_ABOVE,
    OP_PUT_ZERO,
    OP_SEEK_RD,
    OP_NEXT_PASS,
    OP_EVAL_ADV,
    OP_IDX_INC
  } asf_op_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_DROP,
    EMIT_ITEM,
    EMIT_DONE
  } asf_emit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REPLY,
    ST_INS,
    ST_INS_CMP,
    ST_INS_LAST,
    ST_INS_DONE,
    ST_DROP,
    ST_SEEK,
    ST_EVAL
  } asf_state_e;

  typedef struct packed {
    asf_op_e   op;
    asf_emit_e emit;
  } asf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic rdata_lt;
    logic ins_idx_zero;
    logic pass_done;
    logic idx_at_end;
    logic next_at_end;
    logic match;
    logic out_free;
  } asf_sts_t;

endpackage

// File: src/address_sort_and_filter.sv
// Clear and unknown requests reply at once. A full pool drops an insert; else it walks down from
// the top entry, moving each entry below the new address up one slot. A read scans the passes
// for the next hit, or reports sequence_done when they run out; output stalls hold every reply.
// Throughput: one transfer at a time; the next is accepted the cycle after the result loads.
// Reset (rst_ni low, async): pool empty, cursor at pass 0, filter registers at defaults.
// Pool memory contents are not cleared; no clearing pass is needed after reset.
module address_sort_and_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] address_in
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] address_out
  output logic [4:0]  m_axis_tuser_o,   // [1:0] pass_out, [2] item_valid,
                                        // [3] sequence_done, [4] insert_dropped
  // register writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import asf_pkg::*;

  asf_cmd_t cmd;
  asf_sts_t sts;
  asf_req_e req;

  // request codes are the raw tuser bits
  assign req = asf_req_e'(s_axis_tuser_i);

  // controller decides what the datapath does each cycle
  asf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (req),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // pool memory, cursor, filters and result register
  asf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (req),
    .in_addr_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (asf_cfg_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

// File: src/asf_ctrl.sv
// Controller state machine: sequences insert shifts, read scans and replies.
module asf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  asf_pkg::asf_req_e  in_req_i,
  output logic               in_ready_o,
  input  asf_pkg::asf_sts_t  sts_i,
  output asf_pkg::asf_cmd_t  cmd_o
);
  import asf_pkg::*;

  asf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.emit = EMIT_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          unique case (in_req_i)
            REQ_INSERT: state_d = ST_INS;
            REQ_READ:   state_d = ST_SEEK;
            default:    state_d = ST_REPLY;
          endcase
        end
      end
      ST_REPLY, ST_INS_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_ZERO;
          state_d    = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_DROP;
          state_d    = ST_IDLE;
        end
      end
      ST_INS: begin
        priority if (sts_i.full) begin
          state_d = ST_DROP;
        end else if (sts_i.empty) begin
          cmd_o.op = OP_PUT_ZERO;
          state_d  = ST_INS_DONE;
        end else begin
          cmd_o.op = OP_INS_START;
          state_d  = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.rdata_lt) begin
          // entry moves up one slot, keep walking down
          cmd_o.op = OP_INS_SHIFT;
          if (sts_i.ins_idx_zero) begin
            state_d = ST_INS_LAST;
          end
        end else begin
          cmd_o.op = OP_PUT_ABOVE;
          state_d  = ST_INS_DONE;
        end
      end
      ST_INS_LAST: begin
        cmd_o.op = OP_PUT_ZERO;
        state_d  = ST_INS_DONE;
      end
      ST_SEEK: begin
        priority if (sts_i.pass_done) begin
          if (sts_i.out_free) begin
            cmd_o.emit = EMIT_DONE;
            state_d    = ST_IDLE;
          end
        end else if (sts_i.idx_at_end) begin
          cmd_o.op = OP_NEXT_PASS;
        end else begin
          cmd_o.op = OP_SEEK_RD;
          state_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (sts_i.match) begin
          // hold the hit until the output register can take it
          if (sts_i.out_free) begin
            cmd_o.op   = OP_IDX_INC;
            cmd_o.emit = EMIT_ITEM;
            state_d    = ST_IDLE;
          end
        end else if (!sts_i.next_at_end) begin
          cmd_o.op = OP_EVAL_ADV;
        end else begin
          cmd_o.op = OP_IDX_INC;
          state_d  = ST_SEEK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: src/asf_dp.sv
// Datapath: pool memory, count and cursor, filter registers, result register.
module asf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  asf_pkg::asf_req_e                    in_req_i,
  input  asf_pkg::addr_t                       in_addr_i,
  input  logic                                 cfg_we_i,
  input  asf_pkg::asf_cfg_e                    cfg_idx_i,
  input  asf_pkg::octet_t                      cfg_wdata_i,
  input  asf_pkg::asf_cmd_t                    cmd_i,
  output asf_pkg::asf_sts_t                    sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output asf_pkg::addr_t                       out_data_o,
  output logic [asf_pkg::OUT_USER_W-1:0]       out_user_o
);
  import asf_pkg::*;

  addr_t  pool_q [POOL_DEPTH];
  addr_t  rdata_q;
  addr_t  addr_q;
  idx_t   ins_idx_q, ins_idx_d;
  cnt_t   count_q, count_d;
  pass_t  pass_q, pass_d;
  cnt_t   cur_idx_q, cur_idx_d;
  octet_t match_first_q, pair_first_q, pair_second_q, match_any_q;
  logic   out_valid_q, out_valid_d;
  addr_t  out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic   rd_en, we;
  idx_t   raddr, waddr;
  addr_t  wdata;
  logic   hit;
  cnt_t   cur_idx_inc;

  assign cur_idx_inc = cur_idx_q + cnt_t'(1);

  // memory port selection
  always_comb begin
    rd_en = 1'b0;
    we    = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = addr_q;
    unique case (cmd_i.op)
      OP_INS_START: begin
        rd_en = 1'b1;
        raddr = idx_t'(count_q - cnt_t'(1));
      end
      OP_INS_SHIFT: begin
        we    = 1'b1;
        waddr = ins_idx_q + idx_t'(1);
        wdata = rdata_q;
        rd_en = 1'b1;
        raddr = ins_idx_q - idx_t'(1);
      end
      OP_PUT_ABOVE: begin
        we    = 1'b1;
        waddr = ins_idx_q + idx_t'(1);
      end
      OP_PUT_ZERO: begin
        we = 1'b1;
      end
      OP_SEEK_RD: begin
        rd_en = 1'b1;
        raddr = cur_idx_q[AW-1:0];
      end
      OP_EVAL_ADV: begin
        rd_en = 1'b1;
        raddr = cur_idx_q[AW-1:0] + idx_t'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      pool_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= pool_q[raddr];
    end
  end

  // filter for the current pass
  always_comb begin
    unique case (pass_q)
      3'd0: hit = 1'b1;
      3'd1: hit = (rdata_q[31:24] == match_first_q);
      3'd2: hit = (rdata_q[31:24] == pair_first_q) && (rdata_q[23:16] == pair_second_q);
      3'd3: hit = (rdata_q[31:24] == match_any_q) || (rdata_q[23:16] == match_any_q) ||
                  (rdata_q[15:8] == match_any_q) || (rdata_q[7:0] == match_any_q);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    pass_d      = pass_q;
    cur_idx_d   = cur_idx_q;
    ins_idx_d   = ins_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        if (in_req_i == REQ_CLEAR) begin
          count_d = '0;
        end
        if (in_req_i == REQ_CLEAR || in_req_i == REQ_INSERT) begin
          pass_d    = '0;
          cur_idx_d = '0;
        end
      end
      OP_INS_START:             ins_idx_d = idx_t'(count_q - cnt_t'(1));
      OP_INS_SHIFT:             ins_idx_d = ins_idx_q - idx_t'(1);
      OP_PUT_ABOVE, OP_PUT_ZERO: count_d  = count_q + cnt_t'(1);
      OP_NEXT_PASS: begin
        pass_d    = pass_q + pass_t'(1);
        cur_idx_d = '0;
      end
      OP_EVAL_ADV, OP_IDX_INC:  cur_idx_d = cur_idx_inc;
      default: ;
    endcase
    if (cmd_i.emit != EMIT_NONE) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      pass_q        <= '0;
      cur_idx_q     <= '0;
      out_valid_q   <= 1'b0;
      match_first_q <= MATCH_FIRST_RST;
      pair_first_q  <= PAIR_FIRST_RST;
      pair_second_q <= PAIR_SECOND_RST;
      match_any_q   <= MATCH_ANY_RST;
    end else begin
      count_q     <= count_d;
      pass_q      <= pass_d;
      cur_idx_q   <= cur_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MATCH_FIRST: match_first_q <= cfg_wdata_i;
          CFG_PAIR_FIRST:  pair_first_q  <= cfg_wdata_i;
          CFG_PAIR_SECOND: pair_second_q <= cfg_wdata_i;
          CFG_MATCH_ANY:   match_any_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ins_idx_q <= ins_idx_d;
    if (cmd_i.op == OP_CAPTURE) begin
      addr_q <= in_addr_i;
    end
    unique case (cmd_i.emit)
      EMIT_ZERO: begin
        out_data_q <= '0;
        out_user_q <= '0;
      end
      EMIT_DROP: begin
        out_data_q <= '0;
        out_user_q <= OUT_USER_W'(5'b10000);
      end
      EMIT_ITEM: begin
        out_data_q <= rdata_q;
        out_user_q <= {2'b00, 1'b1, pass_q[1:0]};
      end
      EMIT_DONE: begin
        out_data_q <= '0;
        out_user_q <= OUT_USER_W'(5'b01000);
      end
      default: ;
    endcase
  end

  assign sts_o.full         = (count_q == cnt_t'(POOL_DEPTH));
  assign sts_o.empty        = (count_q == '0);
  assign sts_o.rdata_lt     = (rdata_q < addr_q);
  assign sts_o.ins_idx_zero = (ins_idx_q == '0);
  assign sts_o.pass_done    = (pass_q == PASS_END);
  assign sts_o.idx_at_end   = (cur_idx_q >= count_q);
  assign sts_o.next_at_end  = (cur_idx_inc >= count_q);
  assign sts_o.match        = hit;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule
